/* rtl/tpf_pkg.sv */
// tpf_pkg: shared types, codes and helpers of the tabulated pair force unit
// command and result word layouts, status and register codes, saturation helper
// no dependencies
package tpf_pkg;

    // default number of table entries
    localparam int TPF_TABLE_DEPTH = 1024;

    // function codes of a command word
    localparam logic FUNC_WRITE = 1'b0;
    localparam logic FUNC_PAIR  = 1'b1;

    // register indexes on the configuration port (byte address / 4)
    localparam logic [1:0] REG_BOX_LENGTH      = 2'd0;
    localparam logic [1:0] REG_BINS_PER_LENGTH = 2'd1;
    localparam logic [1:0] REG_TABLE_POINTS    = 2'd2;

    // reset values of the registers
    localparam logic [31:0] BOX_LENGTH_RESET      = 32'd655360;
    localparam logic [31:0] BINS_PER_LENGTH_RESET = 32'd6710886;
    localparam logic [10:0] TABLE_POINTS_RESET    = 11'd1024;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_WRITTEN = 2'd1,
        ST_ZERO    = 2'd2,
        ST_BEYOND  = 2'd3
    } status_t;

    typedef struct packed {
        logic        func;
        logic [9:0]  entry_index;
        logic [31:0] entry_force;
        logic [31:0] entry_potential;
        logic [31:0] pos_i_x;
        logic [31:0] pos_i_y;
        logic [31:0] pos_i_z;
        logic [31:0] pos_j_x;
        logic [31:0] pos_j_y;
        logic [31:0] pos_j_z;
    } cmd_t;

    typedef struct packed {
        logic [31:0] force_x;
        logic [31:0] force_y;
        logic [31:0] force_z;
        logic [31:0] pair_potential;
        logic [31:0] pair_virial;
        status_t     status;
    } result_t;

    // signed 32 bit value from sign and magnitude, saturated
    function automatic logic [31:0] sat32(input logic neg, input logic [47:0] mag);
        logic [31:0] res;
        if (neg) begin
            if (mag >= 48'h0000_8000_0000) begin
                res = 32'h8000_0000;
            end
            else begin
                res = 32'(~mag + 48'd1);
            end
        end
        else begin
            if (mag > 48'h0000_7FFF_FFFF) begin
                res = 32'h7FFF_FFFF;
            end
            else begin
                res = mag[31:0];
            end
        end
        return res;
    endfunction

endpackage

/* rtl/tabulated_pair_force_unit.sv */
// tabulated_pair_force_unit: pipelined pair force kernel with force and potential tables
// one module, fold dividers, square root and force dividers as unrolled stage chains
// depends on tpf_pkg
//
// A word is accepted whenever start is high (busy stays low: a new word may enter every
// cycle). Its result is on result with a one-cycle done strobe, in order; the result side
// cannot stall, so every word gives one done strobe.
// The pipeline is a chain of 34 periodic-fold remainder steps, 32 square root
// steps and 32 force division steps, one step per register stage, plus the table read.
// A table write word takes the same path and writes the table in the lookup stage, so
// it is seen by every pair word accepted after it. Configuration must be written only
// while no word is in flight.
module tabulated_pair_force_unit #(
    parameter int TABLE_DEPTH = tpf_pkg::TPF_TABLE_DEPTH
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  tpf_pkg::cmd_t    cmd,
    output logic             done,
    output tpf_pkg::result_t result,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [3:0]       paddr,
    input  logic [31:0]      pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);
    import tpf_pkg::*;

    localparam int AW         = $clog2(TABLE_DEPTH);
    localparam int FOLD_STEPS = 34;
    localparam int SQRT_STEPS = 32;
    localparam int DIV_STEPS  = 32;

    typedef struct packed {
        logic        func;
        logic [9:0]  entry_index;
        logic [31:0] entry_force;
        logic [31:0] entry_potential;
    } side_t;

    typedef struct packed {
        logic             valid;
        side_t            side;
        logic [2:0]       dneg;
        logic [2:0][31:0] mag;
        logic [2:0][33:0] num;
        logic [2:0][33:0] rem;
    } fold_t;

    typedef struct packed {
        logic             valid;
        side_t            side;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
    } geo_t;

    typedef struct packed {
        logic             valid;
        side_t            side;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic [2:0][63:0] sq;
    } sqr_t;

    typedef struct packed {
        logic             valid;
        side_t            side;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic [63:0]      rad;
        logic [34:0]      rem;
        logic [31:0]      root;
    } root_t;

    typedef struct packed {
        logic             valid;
        side_t            side;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic [31:0]      r;
        logic [63:0]      p;
    } prd_t;

    typedef struct packed {
        logic             valid;
        status_t          status;
        logic             wr_en;
        logic [AW-1:0]    waddr;
        logic [AW-1:0]    raddr;
        logic [63:0]      wdata;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic [31:0]      r;
    } look_t;

    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic [31:0]      r;
    } mst_t;

    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [2:0]       neg;
        logic [2:0][31:0] mag;
        logic [31:0]      r;
        logic             fneg;
        logic [31:0]      fmag;
        logic [31:0]      pot;
    } frc_t;

    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [2:0]       neg;
        logic             fneg;
        logic [31:0]      r;
        logic [31:0]      pot;
        logic [2:0][63:0] prod;
        logic [63:0]      vir;
    } mul_t;

    typedef struct packed {
        logic             valid;
        status_t          status;
        logic [2:0]       neg;
        logic             fneg;
        logic [2:0]       ovf;
        logic [2:0][63:0] prod;
        logic [2:0][32:0] rem;
        logic [2:0][31:0] quo;
        logic [31:0]      r;
        logic [31:0]      pot;
        logic [47:0]      vir;
    } div_t;

    // configuration registers
    logic [31:0] box_len_reg;
    logic [31:0] bins_reg;
    logic [10:0] points_reg;

    logic        cfg_wr;
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    // register writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            box_len_reg <= BOX_LENGTH_RESET;
            bins_reg    <= BINS_PER_LENGTH_RESET;
            points_reg  <= TABLE_POINTS_RESET;
        end
        else if (cfg_wr)
        begin
            case (paddr[3:2])
                REG_BOX_LENGTH:      box_len_reg <= pwdata;
                REG_BINS_PER_LENGTH: bins_reg    <= pwdata;
                REG_TABLE_POINTS:    points_reg  <= pwdata[10:0];
                default: ;
            endcase
        end
    end

    // register reads
    always_comb
    begin
        case (paddr[3:2])
            REG_BOX_LENGTH:      prdata = box_len_reg;
            REG_BINS_PER_LENGTH: prdata = bins_reg;
            REG_TABLE_POINTS:    prdata = {21'd0, points_reg};
            default:             prdata = 32'd0;
        endcase
    end

    // never stalls
    assign busy = 1'b0;

    // input word register
    cmd_t cmd_reg;
    logic cmd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
        end
        else
        begin
            cmd_valid_reg <= start & ~busy;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start & ~busy)
        begin
            cmd_reg <= cmd;
        end
    end

    // displacement per axis and fold numerator 2|d| + L
    fold_t fold_reg  [FOLD_STEPS+1];
    fold_t fold_next [FOLD_STEPS+1];

    always_comb
    begin
        logic [2:0][31:0] pa;
        logic [2:0][31:0] pb;
        logic [32:0]      d;
        pa = {cmd_reg.pos_i_z, cmd_reg.pos_i_y, cmd_reg.pos_i_x};
        pb = {cmd_reg.pos_j_z, cmd_reg.pos_j_y, cmd_reg.pos_j_x};
        fold_next[0]                      = '0;
        fold_next[0].valid                = cmd_valid_reg;
        fold_next[0].side.func            = cmd_reg.func;
        fold_next[0].side.entry_index     = cmd_reg.entry_index;
        fold_next[0].side.entry_force     = cmd_reg.entry_force;
        fold_next[0].side.entry_potential = cmd_reg.entry_potential;
        for (int k = 0; k < 3; k++)
        begin
            d = {1'b0, pa[k]} - {1'b0, pb[k]};
            fold_next[0].dneg[k] = d[32];
            fold_next[0].mag[k]  = d[32] ? 32'(-d) : d[31:0];
            fold_next[0].num[k]  = {1'b0, fold_next[0].mag[k], 1'b0} + 34'(box_len_reg);
        end
    end

    // remainder of numerator by 2L, one bit per stage
    for (genvar s = 0; s < FOLD_STEPS; s++)
    begin : g_fold
        always_comb
        begin
            logic [33:0] sh;
            fold_next[s+1] = fold_reg[s];
            for (int k = 0; k < 3; k++)
            begin
                sh = {fold_reg[s].rem[k][32:0], fold_reg[s].num[k][FOLD_STEPS-1-s]};
                if (sh >= {1'b0, box_len_reg, 1'b0})
                begin
                    fold_next[s+1].rem[k] = sh - {1'b0, box_len_reg, 1'b0};
                end
                else
                begin
                    fold_next[s+1].rem[k] = sh;
                end
            end
        end
    end

    for (genvar s = 0; s <= FOLD_STEPS; s++)
    begin : g_fold_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                fold_reg[s] <= '0;
            end
            else
            begin
                fold_reg[s] <= fold_next[s];
            end
        end
    end

    // folded displacement: (rem - L) / 2 with the sign of d, or d itself when L is zero
    geo_t geo_reg;
    geo_t geo_next;

    always_comb
    begin
        logic [34:0] x;
        logic [34:0] ax;
        geo_next.valid = fold_reg[FOLD_STEPS].valid;
        geo_next.side  = fold_reg[FOLD_STEPS].side;
        for (int k = 0; k < 3; k++)
        begin
            x  = {1'b0, fold_reg[FOLD_STEPS].rem[k]} - 35'(box_len_reg);
            ax = x[34] ? -x : x;
            if (box_len_reg == 32'd0)
            begin
                geo_next.neg[k] = fold_reg[FOLD_STEPS].dneg[k];
                geo_next.mag[k] = fold_reg[FOLD_STEPS].mag[k];
            end
            else
            begin
                geo_next.neg[k] = fold_reg[FOLD_STEPS].dneg[k] ^ x[34];
                geo_next.mag[k] = ax[32:1];
            end
        end
    end

    // squares per axis
    sqr_t sqr_reg;
    sqr_t sqr_next;

    always_comb
    begin
        sqr_next.valid = geo_reg.valid;
        sqr_next.side  = geo_reg.side;
        sqr_next.neg   = geo_reg.neg;
        sqr_next.mag   = geo_reg.mag;
        for (int k = 0; k < 3; k++)
        begin
            sqr_next.sq[k] = 64'(geo_reg.mag[k]) * 64'(geo_reg.mag[k]);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            geo_reg <= '0;
            sqr_reg <= '0;
        end
        else
        begin
            geo_reg <= geo_next;
            sqr_reg <= sqr_next;
        end
    end

    // sum of squares, then integer square root two radicand bits per stage
    root_t root_reg  [SQRT_STEPS+1];
    root_t root_next [SQRT_STEPS+1];

    always_comb
    begin
        root_next[0].valid = sqr_reg.valid;
        root_next[0].side  = sqr_reg.side;
        root_next[0].neg   = sqr_reg.neg;
        root_next[0].mag   = sqr_reg.mag;
        root_next[0].rad   = sqr_reg.sq[0] + sqr_reg.sq[1] + sqr_reg.sq[2];
        root_next[0].rem   = '0;
        root_next[0].root  = '0;
    end

    for (genvar s = 0; s < SQRT_STEPS; s++)
    begin : g_sqrt
        always_comb
        begin
            logic [34:0] sh;
            logic [34:0] trial;
            sh    = {root_reg[s].rem[32:0], root_reg[s].rad[63-2*s -: 2]};
            trial = {1'b0, root_reg[s].root, 2'b01};
            root_next[s+1] = root_reg[s];
            if (sh >= trial)
            begin
                root_next[s+1].rem  = sh - trial;
                root_next[s+1].root = {root_reg[s].root[30:0], 1'b1};
            end
            else
            begin
                root_next[s+1].rem  = sh;
                root_next[s+1].root = {root_reg[s].root[30:0], 1'b0};
            end
        end
    end

    for (genvar s = 0; s <= SQRT_STEPS; s++)
    begin : g_root_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                root_reg[s] <= '0;
            end
            else
            begin
                root_reg[s] <= root_next[s];
            end
        end
    end

    // table position r * bins_per_length
    prd_t prd_reg;
    prd_t prd_next;

    always_comb
    begin
        prd_next.valid = root_reg[SQRT_STEPS].valid;
        prd_next.side  = root_reg[SQRT_STEPS].side;
        prd_next.neg   = root_reg[SQRT_STEPS].neg;
        prd_next.mag   = root_reg[SQRT_STEPS].mag;
        prd_next.r     = root_reg[SQRT_STEPS].root;
        prd_next.p     = 64'(root_reg[SQRT_STEPS].root) * 64'(bins_reg);
    end

    // index ceil(p) - 1, range check, table write setup
    look_t look_reg;
    look_t look_next;

    always_comb
    begin
        logic [32:0] q;
        logic [32:0] limit;
        q     = {1'b0, prd_reg.p[63:32]} + 33'(prd_reg.p[31:0] != 32'd0);
        limit = (33'(points_reg) > 33'(TABLE_DEPTH)) ? 33'(TABLE_DEPTH) : 33'(points_reg);
        look_next.valid = prd_reg.valid;
        look_next.neg   = prd_reg.neg;
        look_next.mag   = prd_reg.mag;
        look_next.r     = prd_reg.r;
        look_next.waddr = AW'(prd_reg.side.entry_index);
        look_next.raddr = AW'(q - 33'd1);
        look_next.wdata = {prd_reg.side.entry_potential, prd_reg.side.entry_force};
        look_next.wr_en = prd_reg.valid && (prd_reg.side.func == FUNC_WRITE)
                          && (33'(prd_reg.side.entry_index) < 33'(TABLE_DEPTH));
        if (prd_reg.side.func == FUNC_WRITE)
        begin
            look_next.status = ST_WRITTEN;
        end
        else if (prd_reg.r == 32'd0)
        begin
            look_next.status = ST_ZERO;
        end
        else if ((q == 33'd0) || ((q - 33'd1) >= limit))
        begin
            look_next.status = ST_BEYOND;
        end
        else
        begin
            look_next.status = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prd_reg  <= '0;
            look_reg <= '0;
        end
        else
        begin
            prd_reg  <= prd_next;
            look_reg <= look_next;
        end
    end

    // force and potential table, potential in the upper half
    logic [63:0] tbl_mem [TABLE_DEPTH];
    logic [63:0] rd_reg;
    mst_t        mst_reg;

    always_ff @(posedge clk)
    begin
        if (look_reg.wr_en)
        begin
            tbl_mem[look_reg.waddr] <= look_reg.wdata;
        end
        rd_reg <= tbl_mem[look_reg.raddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mst_reg <= '0;
        end
        else
        begin
            mst_reg.valid  <= look_reg.valid;
            mst_reg.status <= look_reg.status;
            mst_reg.neg    <= look_reg.neg;
            mst_reg.mag    <= look_reg.mag;
            mst_reg.r      <= look_reg.r;
        end
    end

    // force sign and magnitude
    frc_t frc_reg;
    frc_t frc_next;

    always_comb
    begin
        frc_next.valid  = mst_reg.valid;
        frc_next.status = mst_reg.status;
        frc_next.neg    = mst_reg.neg;
        frc_next.mag    = mst_reg.mag;
        frc_next.r      = mst_reg.r;
        frc_next.fneg   = rd_reg[31];
        frc_next.fmag   = rd_reg[31] ? (~rd_reg[31:0] + 32'd1) : rd_reg[31:0];
        frc_next.pot    = rd_reg[63:32];
    end

    // products f * |d| per axis and r * f
    mul_t mul_reg;
    mul_t mul_next;

    always_comb
    begin
        mul_next.valid  = frc_reg.valid;
        mul_next.status = frc_reg.status;
        mul_next.fneg   = frc_reg.fneg;
        mul_next.r      = frc_reg.r;
        mul_next.pot    = frc_reg.pot;
        for (int k = 0; k < 3; k++)
        begin
            mul_next.neg[k]  = frc_reg.neg[k] ^ frc_reg.fneg;
            mul_next.prod[k] = 64'(frc_reg.fmag) * 64'(frc_reg.mag[k]);
        end
        mul_next.vir = 64'(frc_reg.r) * 64'(frc_reg.fmag);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frc_reg <= '0;
            mul_reg <= '0;
        end
        else
        begin
            frc_reg <= frc_next;
            mul_reg <= mul_next;
        end
    end

    // division of products by r, one quotient bit per stage, upper half checked for overflow
    div_t div_reg  [DIV_STEPS+1];
    div_t div_next [DIV_STEPS+1];

    always_comb
    begin
        div_next[0].valid  = mul_reg.valid;
        div_next[0].status = mul_reg.status;
        div_next[0].neg    = mul_reg.neg;
        div_next[0].fneg   = mul_reg.fneg;
        div_next[0].prod   = mul_reg.prod;
        div_next[0].r      = mul_reg.r;
        div_next[0].pot    = mul_reg.pot;
        div_next[0].vir    = mul_reg.vir[63:16];
        div_next[0].quo    = '0;
        for (int k = 0; k < 3; k++)
        begin
            div_next[0].ovf[k] = mul_reg.prod[k][63:32] >= mul_reg.r;
            div_next[0].rem[k] = {1'b0, mul_reg.prod[k][63:32]};
        end
    end

    for (genvar s = 0; s < DIV_STEPS; s++)
    begin : g_div
        always_comb
        begin
            logic [32:0] sh;
            div_next[s+1] = div_reg[s];
            for (int k = 0; k < 3; k++)
            begin
                sh = {div_reg[s].rem[k][31:0], div_reg[s].prod[k][DIV_STEPS-1-s]};
                if (sh >= {1'b0, div_reg[s].r})
                begin
                    div_next[s+1].rem[k] = sh - {1'b0, div_reg[s].r};
                    div_next[s+1].quo[k] = {div_reg[s].quo[k][30:0], 1'b1};
                end
                else
                begin
                    div_next[s+1].rem[k] = sh;
                    div_next[s+1].quo[k] = {div_reg[s].quo[k][30:0], 1'b0};
                end
            end
        end
    end

    for (genvar s = 0; s <= DIV_STEPS; s++)
    begin : g_div_reg
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                div_reg[s] <= '0;
            end
            else
            begin
                div_reg[s] <= div_next[s];
            end
        end
    end

    // result word, zero fields unless the pair is in the table
    result_t result_reg;
    result_t result_next;
    logic    done_reg;
    div_t    dl;

    assign dl = div_reg[DIV_STEPS];

    always_comb
    begin
        logic [2:0][31:0] fo;
        for (int k = 0; k < 3; k++)
        begin
            fo[k] = sat32(dl.neg[k], dl.ovf[k] ? 48'hFFFF_FFFF_FFFF : {16'd0, dl.quo[k]});
        end
        result_next        = '0;
        result_next.status = dl.status;
        if (dl.status == ST_OK)
        begin
            result_next.force_x        = fo[0];
            result_next.force_y        = fo[1];
            result_next.force_z        = fo[2];
            result_next.pair_potential = dl.pot;
            result_next.pair_virial    = sat32(dl.fneg, dl.vir);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dl.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    // a word leaving the division chain is strobed out next cycle
    a_done_follows: assert property (@(posedge clk) disable iff (!rst_n)
        dl.valid |=> done)
        else $error("result word lost at output stage");

    // an in-table pair never has zero distance
    a_ok_nonzero_r: assert property (@(posedge clk) disable iff (!rst_n)
        (look_reg.valid && look_reg.status == ST_OK) |-> (look_reg.r != 32'd0))
        else $error("pair passed range check with zero distance");

    // table reads stay inside the depth
    a_raddr_range: assert property (@(posedge clk) disable iff (!rst_n)
        (look_reg.valid && look_reg.status == ST_OK)
        |-> (33'(look_reg.raddr) < 33'(TABLE_DEPTH)))
        else $error("table read address out of range");

    // table writes only come from write words
    a_write_status: assert property (@(posedge clk) disable iff (!rst_n)
        look_reg.wr_en |-> (look_reg.valid && look_reg.status == ST_WRITTEN))
        else $error("table write without write word");

    // flagged words carry zero values
    a_flag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && result.status != ST_OK)
        |-> (result.force_x == 32'd0 && result.pair_potential == 32'd0
             && result.pair_virial == 32'd0))
        else $error("flagged result carries nonzero values");

endmodule
